[src/tts_pkg.sv]
// Shared types and constants for the trilinear table sampler.
package tts_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_ORG_R = 3'd0;
  localparam logic [2:0] REG_ORG_L = 3'd1;
  localparam logic [2:0] REG_ORG_E = 3'd2;
  localparam logic [2:0] REG_INV_R = 3'd3;
  localparam logic [2:0] REG_INV_L = 3'd4;
  localparam logic [2:0] REG_INV_E = 3'd5;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // Classified item passed from front end to back end
  typedef struct packed {
    logic        is_write;
    logic        in_cell;
    logic [7:0]  idx_r;
    logic [7:0]  idx_l;
    logic [7:0]  idx_e;
    logic [15:0] frac_r;
    logic [15:0] frac_l;
    logic [15:0] frac_e;
    logic [15:0] wr_value;
  } tts_cmd_t;

  // Floor-shift lerp: a + (((b-a)*f) >> 16)
  function automatic logic signed [15:0] tts_lerp(input logic signed [15:0] a,
                                                   input logic signed [15:0] b,
                                                   input logic [15:0] f);
    logic signed [16:0] d;
    logic signed [33:0] p;
    logic signed [17:0] s;
    d = 17'(b) - 17'(a);
    p = 34'(d) * $signed({1'b0, f});
    s = 18'(p >>> 16);
    return 16'(18'(a) + s);
  endfunction

endpackage

[src/trilinear_table_sampler_top.sv]
// A sample item passes through eight reads from one table memory port, a drain
// state and three blend steps; a write item or a sample outside the table skips
// them. The back end takes a new item only from its idle state.
// Reset (rst_n, synchronous): control and registers return to defaults;
// table contents are undefined until written, no clearing pass.
// Front end and back end run decoupled through a two-entry queue.
module trilinear_table_sampler_top import tts_pkg::*; #(
  parameter int RADIAL_SAMPLES      = 16,
  parameter int LATERAL_SAMPLES     = 16,
  parameter int ELEVATIONAL_SAMPLES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: coord_radial[31:0], coord_lateral[63:32], coord_elevational[95:64],
  // write_radial_index[103:96], write_lateral_index[111:104],
  // write_elevational_index[119:112], write_value[135:120], zero fill
  input  logic [143:0] in_tdata,
  input  logic         in_tuser,   // action
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [15:0]  out_tdata,  // profile_value
  output logic         out_tuser,  // inside_res
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [31:0] org_r_r, org_l_r, org_e_r, inv_r_r, inv_l_r, inv_e_r;
  logic [2:0]  ridx;

  // Register file
  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[4:2];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r_r <= '0; org_l_r <= '0; org_e_r <= '0;
      inv_r_r <= 32'd65536; inv_l_r <= 32'd65536; inv_e_r <= 32'd65536;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'd0) begin
      case (ridx)
        REG_ORG_R: org_r_r <= cfg_pwdata;
        REG_ORG_L: org_l_r <= cfg_pwdata;
        REG_ORG_E: org_e_r <= cfg_pwdata;
        REG_INV_R: inv_r_r <= cfg_pwdata;
        REG_INV_L: inv_l_r <= cfg_pwdata;
        REG_INV_E: inv_e_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_ORG_R: cfg_prdata = org_r_r;
      REG_ORG_L: cfg_prdata = org_l_r;
      REG_ORG_E: cfg_prdata = org_e_r;
      REG_INV_R: cfg_prdata = inv_r_r;
      REG_INV_L: cfg_prdata = inv_l_r;
      REG_INV_E: cfg_prdata = inv_e_r;
      default:   cfg_prdata = 32'd0;
    endcase
  end

  tts_cmd_t f_cmd, q_cmd;
  logic f_valid, f_ready, q_valid, q_ready;
  logic b_valid, b_ready, b_inside;
  logic [15:0] b_value;

  tts_front #(RADIAL_SAMPLES, LATERAL_SAMPLES, ELEVATIONAL_SAMPLES) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .action(in_tuser),
    .coord_r(in_tdata[31:0]), .coord_l(in_tdata[63:32]), .coord_e(in_tdata[95:64]),
    .wr_r(in_tdata[103:96]), .wr_l(in_tdata[111:104]), .wr_e(in_tdata[119:112]),
    .wr_value(in_tdata[135:120]),
    .org_r(org_r_r), .org_l(org_l_r), .org_e(org_e_r),
    .inv_r(inv_r_r), .inv_l(inv_l_r), .inv_e(inv_e_r),
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd));

  tts_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd));

  tts_back #(RADIAL_SAMPLES, LATERAL_SAMPLES, ELEVATIONAL_SAMPLES) u_back (
    .clk, .rst_n, .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .res_valid(b_valid), .res_ready(b_ready), .res_value(b_value),
    .res_inside(b_inside));

  tts_out u_out (
    .clk, .rst_n, .in_valid(b_valid), .in_ready(b_ready), .in_value(b_value),
    .in_inside(b_inside), .out_valid(out_tvalid), .out_ready(out_tready),
    .out_value(out_tdata), .out_inside(out_tuser));

endmodule

[src/tts_front.sv]
// Front end: maps coordinates into index space and classifies each item.
module tts_front import tts_pkg::*; #(
  parameter int RADIAL_SAMPLES      = 16,
  parameter int LATERAL_SAMPLES     = 16,
  parameter int ELEVATIONAL_SAMPLES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [31:0] coord_r,
  input  logic [31:0] coord_l,
  input  logic [31:0] coord_e,
  input  logic [7:0]  wr_r,
  input  logic [7:0]  wr_l,
  input  logic [7:0]  wr_e,
  input  logic [15:0] wr_value,
  input  logic [31:0] org_r,
  input  logic [31:0] org_l,
  input  logic [31:0] org_e,
  input  logic [31:0] inv_r,
  input  logic [31:0] inv_l,
  input  logic [31:0] inv_e,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output tts_cmd_t    cmd
);

  // Sequencer: one axis multiply per cycle, then hand off
  logic        busy_r, busy_nxt;
  logic [1:0]  axis_r, axis_nxt;
  logic        done_r, done_nxt;
  tts_cmd_t    cmd_r, cmd_nxt;
  logic        ok_r, ok_nxt;
  logic [31:0] cr_r, cl_r, ce_r;
  logic [31:0] cr_nxt, cl_nxt, ce_nxt;

  logic signed [32:0] diff;
  logic [31:0]        inv_sel;
  logic [8:0]         n_sel;
  logic [63:0]        prod;
  logic               ax_ok;

  assign in_ready  = !busy_r && !done_r;
  assign cmd_valid = done_r;
  assign cmd       = cmd_r;

  // Axis mux and Q32.32 product
  always_comb begin
    case (axis_r)
      2'd0: begin
        diff = 33'($signed(cr_r)) - 33'($signed(org_r));
        inv_sel = inv_r; n_sel = 9'(RADIAL_SAMPLES);
      end
      2'd1: begin
        diff = 33'($signed(cl_r)) - 33'($signed(org_l));
        inv_sel = inv_l; n_sel = 9'(LATERAL_SAMPLES);
      end
      default: begin
        diff = 33'($signed(ce_r)) - 33'($signed(org_e));
        inv_sel = inv_e; n_sel = 9'(ELEVATIONAL_SAMPLES);
      end
    endcase
    prod = (diff[32] ? 32'd0 : diff[31:0]) * inv_sel;
    ax_ok = !(diff[32] && inv_sel != 32'd0) &&
            ({1'b0, prod[63:32]} + 33'd1 < 33'(n_sel));
  end

  always_comb begin
    busy_nxt = busy_r; axis_nxt = axis_r; done_nxt = done_r;
    cmd_nxt = cmd_r; ok_nxt = ok_r;
    cr_nxt = cr_r; cl_nxt = cl_r; ce_nxt = ce_r;
    if (done_r && cmd_ready) done_nxt = 1'b0;
    if (in_valid && in_ready) begin
      cmd_nxt.is_write = (action == ACT_WRITE);
      cmd_nxt.wr_value = wr_value;
      cr_nxt = coord_r; cl_nxt = coord_l; ce_nxt = coord_e;
      if (action == ACT_WRITE) begin
        cmd_nxt.idx_r = wr_r; cmd_nxt.idx_l = wr_l; cmd_nxt.idx_e = wr_e;
        cmd_nxt.in_cell = (9'(wr_r) < 9'(RADIAL_SAMPLES)) &&
                          (9'(wr_l) < 9'(LATERAL_SAMPLES)) &&
                          (9'(wr_e) < 9'(ELEVATIONAL_SAMPLES));
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1; axis_nxt = 2'd0; ok_nxt = 1'b1;
      end
    end else if (busy_r) begin
      case (axis_r)
        2'd0: begin cmd_nxt.idx_r = prod[39:32]; cmd_nxt.frac_r = prod[31:16]; end
        2'd1: begin cmd_nxt.idx_l = prod[39:32]; cmd_nxt.frac_l = prod[31:16]; end
        default: begin cmd_nxt.idx_e = prod[39:32]; cmd_nxt.frac_e = prod[31:16]; end
      endcase
      ok_nxt = ok_r && ax_ok;
      if (axis_r == 2'd2) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
        cmd_nxt.in_cell = ok_r && ax_ok;
      end else begin
        axis_nxt = axis_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; axis_r <= 2'd0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; axis_r <= axis_nxt;
    end
    cmd_r <= cmd_nxt; ok_r <= ok_nxt;
    cr_r <= cr_nxt; cl_r <= cl_nxt; ce_r <= ce_nxt;
  end

endmodule

[src/tts_queue.sv]
// Two-entry queue between front end and back end.
module tts_queue import tts_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  tts_cmd_t wr_data,
  output logic     rd_valid,
  input  logic     rd_ready,
  output tts_cmd_t rd_data
);

  tts_cmd_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) mem_r[wp_r] <= wr_data;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !wr_ready) else $error("queue overflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count invalid");
  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> cnt_r == $past(cnt_r) - 2'd1) else $error("queue count slip");
`endif

endmodule

[src/tts_back.sv]
// Back end: table memory, eight corner reads and the lerp tree.
module tts_back import tts_pkg::*; #(
  parameter int RADIAL_SAMPLES      = 16,
  parameter int LATERAL_SAMPLES     = 16,
  parameter int ELEVATIONAL_SAMPLES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  tts_cmd_t    cmd,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [15:0] res_value,
  output logic        res_inside
);

  localparam int DEPTH = RADIAL_SAMPLES * LATERAL_SAMPLES * ELEVATIONAL_SAMPLES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_READ  = 7'b0000010,
    ST_DRAIN = 7'b0000100,
    ST_MIXR  = 7'b0001000,
    ST_MIXL  = 7'b0010000,
    ST_MIXE  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } st_t;

  logic [15:0] mem [DEPTH];
  st_t         st_r, st_nxt;
  tts_cmd_t    c_r;
  logic [3:0]  k_r;
  logic [15:0] rd_r;
  logic [15:0] v_r [8];
  logic [15:0] m_r [4];
  logic [15:0] n_r [2];
  logic [15:0] val_r;
  logic        ins_r;
  logic [AW-1:0] addr;
  logic [8:0]  rr, ll, ee;
  logic [15:0] c00, c10, c01, c11, c0, c1;

  // Corner address: bit0 radial, bit1 lateral, bit2 elevational
  always_comb begin
    rr = 9'(c_r.idx_r) + 9'(k_r[0]);
    ll = 9'(c_r.idx_l) + 9'(k_r[1]);
    ee = 9'(c_r.idx_e) + 9'(k_r[2]);
    addr = AW'((32'(rr) * LATERAL_SAMPLES + 32'(ll)) * ELEVATIONAL_SAMPLES + 32'(ee));
  end

  assign cmd_ready = (st_r == ST_IDLE);
  assign res_valid = (st_r == ST_OUT);
  assign res_value = val_r;
  assign res_inside = ins_r;

  // Radial lerps from registered corners, lateral lerps from registered radial pairs
  assign c00 = tts_lerp(v_r[0], v_r[1], c_r.frac_r);
  assign c10 = tts_lerp(v_r[2], v_r[3], c_r.frac_r);
  assign c01 = tts_lerp(v_r[4], v_r[5], c_r.frac_r);
  assign c11 = tts_lerp(v_r[6], v_r[7], c_r.frac_r);
  assign c0  = tts_lerp(m_r[0], m_r[1], c_r.frac_l);
  assign c1  = tts_lerp(m_r[2], m_r[3], c_r.frac_l);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (cmd_valid) begin
        if (cmd.is_write || !cmd.in_cell) st_nxt = ST_OUT;
        else st_nxt = ST_READ;
      end
      ST_READ:  if (k_r == 4'd7) st_nxt = ST_DRAIN;
      ST_DRAIN: st_nxt = ST_MIXR;
      ST_MIXR:  st_nxt = ST_MIXL;
      ST_MIXL:  st_nxt = ST_MIXE;
      ST_MIXE:  st_nxt = ST_OUT;
      ST_OUT:   if (res_ready) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else st_r <= st_nxt;
    rd_r <= mem[addr];
    case (st_r)
      ST_IDLE: if (cmd_valid) begin
        c_r <= cmd; k_r <= 4'd0; ins_r <= cmd.in_cell; val_r <= 16'd0;
      end
      ST_READ: begin
        k_r <= k_r + 4'd1;
        if (k_r != 4'd0) v_r[3'(k_r - 4'd1)] <= rd_r;
      end
      ST_DRAIN: begin
        v_r[7] <= rd_r;
      end
      ST_MIXR: begin
        m_r[0] <= c00; m_r[1] <= c10; m_r[2] <= c01; m_r[3] <= c11;
      end
      ST_MIXL: begin
        n_r[0] <= c0; n_r[1] <= c1;
      end
      ST_MIXE: begin
        val_r <= tts_lerp(n_r[0], n_r[1], c_r.frac_e);
      end
      default: ;
    endcase
    if (st_r == ST_IDLE && cmd_valid && cmd.is_write && cmd.in_cell)
      mem[AW'((32'(cmd.idx_r) * LATERAL_SAMPLES + 32'(cmd.idx_l)) * ELEVATIONAL_SAMPLES
              + 32'(cmd.idx_e))] <= cmd.wr_value;
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(st_r)) else $error("state not one-hot");
  a_read_len: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_READ |-> k_r <= 4'd7) else $error("read count overrun");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_OUT && !res_ready |=> st_r == ST_OUT) else $error("result dropped");
`endif

endmodule

[src/tts_out.sv]
// Output stage: registered result toward the output port.
module tts_out import tts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_value,
  input  logic        in_inside,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_value,
  output logic        out_inside
);
  logic        v_r;
  logic [15:0] d_r;
  logic        i_r;

  assign in_ready = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_value = d_r;
  assign out_inside = i_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (in_ready) v_r <= in_valid;
    if (in_ready && in_valid) begin
      d_r <= in_value; i_r <= in_inside;
    end
  end
endmodule

[test/tb_trilinear_table_sampler_top.sv]
// Testbench for the trilinear table sampler: directed table plus predictor-checked random items.
module tb_trilinear_table_sampler_top;
  import tts_pkg::*;

  localparam int NR = 16;
  localparam int NL = 16;
  localparam int NE = 16;
  localparam int DEPTH = NR * NL * NE;
  localparam int RANDOM_ITEMS = 850;
  localparam int HOLD_CYCLES = 250;
  localparam int DRAIN_CYCLES = 40;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [143:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [15:0]  out_tdata;
  logic         out_tuser;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [4:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  typedef struct {
    logic        action;
    logic [31:0] cr, cl, ce;
    logic [7:0]  ir, il, ie;
    logic [15:0] wval;
    bit          typed;
    logic [15:0] exp_val;
    logic        exp_in;
  } row_t;

  typedef struct {
    logic [15:0] value;
    logic        in_cell;
  } profile_t;

  // Predictor state
  logic [15:0] table_mirror [DEPTH];
  bit          written [DEPTH];
  logic [31:0] org [3];
  logic [31:0] inv [3];

  profile_t profile_q [$];
  int       errors;
  bit       quiet;
  bit       hold_req;

  trilinear_table_sampler_top DUT (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Map one coordinate to cell index and fraction; 0 if the cell leaves the table
  function automatic bit map_axis(input logic [31:0] coord, input logic [31:0] origin,
                                  input logic [31:0] istep, input int n,
                                  output int idx, output logic [15:0] frac);
    longint diff;
    logic [63:0] prod;
    diff = longint'($signed(coord)) - longint'($signed(origin));
    idx = 0;
    frac = '0;
    if (diff < 0 && istep != 0) return 0;
    if (diff < 0) diff = 0;
    prod = 64'(diff) * 64'(istep);
    if (prod[63:32] + 64'd1 >= 64'(n)) return 0;
    idx = int'(prod[63:32]);
    frac = prod[31:16];
    return 1;
  endfunction

  function automatic int blend(input int a, input int b, input logic [15:0] f);
    longint x;
    x = longint'(b - a) * longint'({1'b0, f});
    return a + int'(x >>> 16);
  endfunction

  function automatic int addr_of(input int r, input int l, input int e);
    return (r * NL + l) * NE + e;
  endfunction

  function automatic int tap(input int r, input int l, input int e);
    return int'($signed(table_mirror[addr_of(r, l, e)]));
  endfunction

  // Expected profile for one item; also stores write items into the mirror
  function automatic profile_t predict_profile(input row_t it);
    profile_t p;
    int r0, l0, e0;
    logic [15:0] fr, fl, fe;
    int c00, c10, c01, c11, c0, c1;
    p.value = '0;
    p.in_cell = 0;
    if (it.action == ACT_WRITE) begin
      if (it.ir < NR && it.il < NL && it.ie < NE) begin
        table_mirror[addr_of(it.ir, it.il, it.ie)] = it.wval;
        written[addr_of(it.ir, it.il, it.ie)] = 1;
        p.in_cell = 1;
      end
    end else if (map_axis(it.cr, org[0], inv[0], NR, r0, fr) &&
                 map_axis(it.cl, org[1], inv[1], NL, l0, fl) &&
                 map_axis(it.ce, org[2], inv[2], NE, e0, fe)) begin
      c00 = blend(tap(r0, l0, e0), tap(r0 + 1, l0, e0), fr);
      c10 = blend(tap(r0, l0 + 1, e0), tap(r0 + 1, l0 + 1, e0), fr);
      c01 = blend(tap(r0, l0, e0 + 1), tap(r0 + 1, l0, e0 + 1), fr);
      c11 = blend(tap(r0, l0 + 1, e0 + 1), tap(r0 + 1, l0 + 1, e0 + 1), fr);
      c0 = blend(c00, c10, fl);
      c1 = blend(c01, c11, fl);
      p.value = 16'(blend(c0, c1, fe));
      p.in_cell = 1;
    end
    return p;
  endfunction

  // Offer one item, record its expectation, wait for acceptance
  task automatic send_item(input row_t it);
    profile_t p;
    p = predict_profile(it);
    if (it.typed) begin
      p.value = it.exp_val;
      p.in_cell = it.exp_in;
    end
    if (!quiet && $urandom_range(0, 99) < 38) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    profile_q.push_back(p);
    in_tuser  <= it.action;
    in_tdata  <= {8'b0, it.wval, it.ie, it.il, it.ir, it.ce, it.cl, it.cr};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_sample(input int r, input int l, input int e, input logic [15:0] v);
    row_t it;
    it = '{default: '0};
    it.action = ACT_WRITE;
    it.ir = 8'(r);
    it.il = 8'(l);
    it.ie = 8'(e);
    it.wval = v;
    send_item(it);
  endtask

  // Wait for all results, then let the block settle before a register write
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (profile_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] v);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= 5'(idx) << 2;
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx <= REG_ORG_E) org[idx] = v;
    else inv[idx - REG_INV_R] = v;
  endtask

  task automatic set_axes(input logic [31:0] o0, input logic [31:0] o1, input logic [31:0] o2,
                          input logic [31:0] s0, input logic [31:0] s1, input logic [31:0] s2);
    cfg_write(REG_ORG_R, o0);
    cfg_write(REG_ORG_L, o1);
    cfg_write(REG_ORG_E, o2);
    cfg_write(REG_INV_R, s0);
    cfg_write(REG_INV_L, s1);
    cfg_write(REG_INV_E, s2);
  endtask

  // Coordinate that mostly lands inside the table on this axis
  function automatic logic [31:0] pick_coord(input int ax);
    longint span;
    if ($urandom_range(0, 99) < 12) return $urandom();
    if (inv[ax] == 0) span = 64'd1 << 20;
    else span = ((longint'(NR - 1)) << 32) / longint'(inv[ax]);
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    if ($urandom_range(0, 99) < 8) return org[ax] - 32'($urandom_range(1, 65536));
    return org[ax] + 32'(longint'($urandom()) % (span + 1));
  endfunction

  // Random sample; first writes any unwritten corner of its cell
  task automatic random_sample();
    row_t it;
    int r0, l0, e0, dr, dl, de;
    logic [15:0] fr, fl, fe;
    it = '{default: '0};
    it.action = ACT_SAMPLE;
    it.cr = pick_coord(0);
    it.cl = pick_coord(1);
    it.ce = pick_coord(2);
    it.ir = 8'($urandom());
    it.il = 8'($urandom());
    it.ie = 8'($urandom());
    it.wval = 16'($urandom());
    if (map_axis(it.cr, org[0], inv[0], NR, r0, fr) &&
        map_axis(it.cl, org[1], inv[1], NL, l0, fl) &&
        map_axis(it.ce, org[2], inv[2], NE, e0, fe)) begin
      for (dr = 0; dr < 2; dr++)
        for (dl = 0; dl < 2; dl++)
          for (de = 0; de < 2; de++)
            if (!written[addr_of(r0 + dr, l0 + dl, e0 + de)])
              write_sample(r0 + dr, l0 + dl, e0 + de, 16'($urandom()));
    end
    send_item(it);
  endtask

  task automatic random_item();
    row_t it;
    if ($urandom_range(0, 99) < 30) begin
      it = '{default: '0};
      it.action = ACT_WRITE;
      it.cr = $urandom();
      it.cl = $urandom();
      it.ce = $urandom();
      if ($urandom_range(0, 99) < 85) begin
        it.ir = 8'($urandom_range(0, NR - 1));
        it.il = 8'($urandom_range(0, NL - 1));
        it.ie = 8'($urandom_range(0, NE - 1));
      end else begin
        it.ir = 8'($urandom());
        it.il = 8'($urandom());
        it.ie = 8'($urandom());
      end
      it.wval = 16'($urandom());
      send_item(it);
    end else begin
      random_sample();
    end
  endtask

  // Result receiver: random stalls, one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else begin
        out_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 38);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    profile_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (profile_q.size() == 0) begin
        $display("%0t: unexpected item value=%h inside=%b", $time, out_tdata, out_tuser);
        errors++;
      end else begin
        e = profile_q.pop_front();
        if (out_tdata !== e.value) begin
          $display("%0t: profile_value expected %h actual %h", $time, e.value, out_tdata);
          errors++;
        end
        if (out_tuser !== e.in_cell) begin
          $display("%0t: inside_res expected %b actual %b", $time, e.in_cell, out_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Directed rows, default axes (origin 0, step 1.0)
  row_t dir_rows [] = '{
    '{ACT_WRITE, 0, 0, 0, 0, 0, 0, 16'h7FFF, 1, 0, 1},
    '{ACT_WRITE, 0, 0, 0, 1, 0, 0, 16'h1000, 0, 0, 0},
    '{ACT_WRITE, 0, 0, 0, 0, 1, 0, 16'hF000, 0, 0, 0},
    '{ACT_WRITE, 0, 0, 0, 1, 1, 0, 16'h0123, 0, 0, 0},
    '{ACT_WRITE, 0, 0, 0, 0, 0, 1, 16'h2000, 0, 0, 0},
    '{ACT_WRITE, 0, 0, 0, 1, 0, 1, 16'hC000, 0, 0, 0},
    '{ACT_WRITE, 0, 0, 0, 0, 1, 1, 16'h0001, 0, 0, 0},
    '{ACT_WRITE, 0, 0, 0, 1, 1, 1, 16'h8000, 1, 0, 1},
    '{ACT_WRITE, 0, 0, 0, 15, 15, 15, 16'h5555, 1, 0, 1},
    '{ACT_WRITE, 0, 0, 0, 16, 0, 0, 16'h1111, 1, 0, 0},
    '{ACT_WRITE, 0, 0, 0, 0, 255, 0, 16'h2222, 1, 0, 0},
    '{ACT_WRITE, 0, 0, 0, 255, 255, 255, 16'hFFFF, 1, 0, 0},
    '{ACT_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 1, 16'h7FFF, 1},
    '{ACT_SAMPLE, 32'h8000, 32'h8000, 32'h8000, 0, 0, 0, 0, 0, 0, 0},
    '{ACT_SAMPLE, 32'hFFFF, 32'h4000, 32'hC000, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 0, 0, 0},
    '{ACT_SAMPLE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 1, 0, 0},
    '{ACT_SAMPLE, 32'h000F_0000, 0, 0, 0, 0, 0, 0, 1, 0, 0},
    '{ACT_SAMPLE, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 1, 0, 0},
    '{ACT_SAMPLE, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 1, 0, 0}
  };

  initial begin
    errors = 0;
    quiet = 0;
    hold_req = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    for (int i = 0; i < DEPTH; i++) begin
      table_mirror[i] = '0;
      written[i] = 0;
    end
    for (int a = 0; a < 3; a++) begin
      org[a] = '0;
      inv[a] = 32'h0001_0000;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i]);

    // Random phases over several axis settings
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0: set_axes(32'hFFFA_8000, 32'h0003_0000, 32'h0000_0000,
                    32'h0000_8000, 32'h0002_0000, 32'h0001_0000);
        1: set_axes(32'h8000_0000, 32'h0000_1234, 32'hFFFF_0000,
                    32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF);
        2: set_axes(32'h7FF0_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h0010_0000, 32'h0001_8000, 32'h0000_0000);
        default: set_axes(32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0000,
                          32'h0001_0000, 32'h0000_C000, 32'h0003_0000);
      endcase
      for (int k = 0; k < RANDOM_ITEMS / 4; k++) begin
        if (ph == 1 && k == 20) hold_req = 1;
        quiet = (ph == 2 && k >= 60 && k < 160);
        random_item();
      end
      quiet = 0;
    end

    in_tvalid <= 1'b0;
    while (profile_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[trilinear_table_sampler_top.f]
src/tts_pkg.sv
src/tts_front.sv
src/tts_queue.sv
src/tts_back.sv
src/tts_out.sv
src/trilinear_table_sampler_top.sv
test/tb_trilinear_table_sampler_top.sv
